/* rtl/tabd_pkg.sv */
package tabd_pkg;

    localparam int WORD_W    = 32;
    localparam int VER_W     = 8;
    localparam int CELL_W    = 16;
    localparam int CARD_W    = 9;
    localparam int CHAN_W    = 5;
    localparam int ADC_W     = 8;
    localparam int SKIP_W    = 5;
    localparam int GRP_N     = 4;
    localparam int GRP_CNT_W = 3;
    localparam int GRP_IDX_W = 2;

    localparam logic [VER_W-1:0] VER_COMPRESSED = 8'd2;

    // register indexes of the configuration port
    localparam logic REG_EXTRA_HEADER = 1'b0;

    localparam logic CODING_PAIR       = 1'b0;
    localparam logic CODING_COMPRESSED = 1'b1;

    typedef enum logic [1:0] {
        PH_HEADER,
        PH_PATTERN,
        PH_DATA,
        PH_SKIP
    } tabd_phase_t;

    typedef struct packed {
        tabd_phase_t       phase;
        logic [VER_W-1:0]  version;
        logic              drop;
        logic [WORD_W-1:0] pattern;
        logic [SKIP_W-1:0] skip;
        logic [CARD_W-1:0] card;
    } tabd_state_t;

    // up to four results caused by one word, packed from entry 0
    typedef struct packed {
        logic                          coding;
        logic [CARD_W-1:0]             card_code;
        logic [GRP_CNT_W-1:0]          cnt;
        logic [GRP_N-1:0][CELL_W-1:0]  cell_id;
        logic [GRP_N-1:0][CHAN_W-1:0]  channel;
        logic [GRP_N-1:0][ADC_W-1:0]   adc;
    } tabd_grp_t;

    function automatic logic [CHAN_W-1:0] lsb_index(input logic [WORD_W-1:0] p);
        logic [CHAN_W-1:0] idx;
        idx = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (p[b])
            begin
                idx = CHAN_W'(b);
            end
        end
        return idx;
    endfunction

endpackage

/* rtl/tabd_if.sv */
interface tabd_in_if;
    logic                           valid;
    logic                           ready;
    logic [tabd_pkg::WORD_W-1:0]    word;
    logic                           bank_start;
    logic [tabd_pkg::VER_W-1:0]     bank_version;

    modport source (output valid, output word, output bank_start, output bank_version,
                    input ready);
    modport sink (input valid, input word, input bank_start, input bank_version,
                  output ready);
endinterface

interface tabd_out_if;
    logic                           valid;
    logic                           ready;
    logic                           coding;
    logic [tabd_pkg::CELL_W-1:0]    cell_id;
    logic [tabd_pkg::CARD_W-1:0]    card_code;
    logic [tabd_pkg::CHAN_W-1:0]    channel;
    logic [tabd_pkg::ADC_W-1:0]     adc;
    logic                           last;

    modport source (output valid, output coding, output cell_id, output card_code,
                    output channel, output adc, output last, input ready);
    modport sink (input valid, input coding, input cell_id, input card_code,
                  input channel, input adc, input last, output ready);
endinterface

/* rtl/trigger_adc_bank_deframer.sv */
// Channel  Dir  Payload                                          Handshake
// din      in   word[31:0] bank_start bank_version[7:0]          valid/ready
// dout     out  coding cell_id[15:0] card_code[8:0] channel[4:0]  valid/ready
//               adc[7:0] last
// apb      in   psel penable pwrite paddr[2:0] pwdata/prdata      pready tied high
//
// A word is decoded in the cycle it is accepted; its results (zero to four)
// land in a group register and leave one per cycle through the output
// register while dout is ready; a word with more than one result holds the
// input while they drain, so the output port sets the rate.
// A stalled output holds the group; din.ready drops until the group drains.
// rst_n clears decode state, the group count and the output valid at once.
module trigger_adc_bank_deframer (
    input  logic        clk,
    input  logic        rst_n,
    tabd_in_if.sink     din,
    tabd_out_if.source  dout,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    tabd_pkg::tabd_state_t              state_reg;
    tabd_pkg::tabd_state_t              state_next;
    tabd_pkg::tabd_grp_t                grp_next;
    tabd_pkg::tabd_grp_t                grp_reg;
    logic [tabd_pkg::GRP_CNT_W-1:0]     grp_left_reg;
    logic [tabd_pkg::GRP_IDX_W-1:0]     grp_idx_reg;
    logic                               extra_header_reg;
    logic                               out_valid_reg;
    logic                               out_coding_reg;
    logic [tabd_pkg::CELL_W-1:0]        out_cell_reg;
    logic [tabd_pkg::CARD_W-1:0]        out_card_reg;
    logic [tabd_pkg::CHAN_W-1:0]        out_chan_reg;
    logic [tabd_pkg::ADC_W-1:0]         out_adc_reg;
    logic                               out_last_reg;
    logic                               move;
    logic                               in_fire;
    logic                               cfg_write;

    // configuration port: one register, to be written only while idle; the block does not enforce it
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == tabd_pkg::REG_EXTRA_HEADER) ? {31'b0, extra_header_reg}
                                                                 : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            extra_header_reg <= 1'b0;
        end
        else if (cfg_write && (paddr[2] == tabd_pkg::REG_EXTRA_HEADER))
        begin
            extra_header_reg <= pwdata[0];
        end
    end

    tabd_decode u_decode (
        .state        (state_reg),
        .word         (din.word),
        .bank_start   (din.bank_start),
        .bank_version (din.bank_version),
        .extra_header (extra_header_reg),
        .state_next   (state_next),
        .grp          (grp_next)
    );

    // advance one result from the group when the output register frees up
    assign move     = (grp_left_reg != '0) && (!out_valid_reg || dout.ready);
    assign din.ready = (grp_left_reg == '0) || ((grp_left_reg == 3'd1) && move);
    assign in_fire  = din.valid && din.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase   <= tabd_pkg::PH_HEADER;
            state_reg.version <= '0;
            state_reg.drop    <= 1'b0;
            state_reg.pattern <= '0;
            state_reg.skip    <= '0;
            state_reg.card    <= '0;
        end
        else if (in_fire)
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grp_left_reg <= '0;
            grp_idx_reg  <= '0;
        end
        else if (in_fire && (grp_next.cnt != '0))
        begin
            grp_left_reg <= grp_next.cnt;
            grp_idx_reg  <= '0;
        end
        else if (move)
        begin
            grp_left_reg <= grp_left_reg - tabd_pkg::GRP_CNT_W'(1);
            grp_idx_reg  <= grp_idx_reg + tabd_pkg::GRP_IDX_W'(1);
        end
    end

    // group payload: no reset
    always_ff @(posedge clk)
    begin
        if (in_fire && (grp_next.cnt != '0))
        begin
            grp_reg <= grp_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (move)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (dout.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_coding_reg <= grp_reg.coding;
            out_card_reg   <= grp_reg.card_code;
            out_cell_reg   <= grp_reg.cell_id[grp_idx_reg];
            out_chan_reg   <= grp_reg.channel[grp_idx_reg];
            out_adc_reg    <= grp_reg.adc[grp_idx_reg];
            out_last_reg   <= (grp_left_reg == 3'd1);
        end
    end

    assign dout.valid     = out_valid_reg;
    assign dout.coding    = out_coding_reg;
    assign dout.cell_id   = out_cell_reg;
    assign dout.card_code = out_card_reg;
    assign dout.channel   = out_chan_reg;
    assign dout.adc       = out_adc_reg;
    assign dout.last      = out_last_reg;

    // group never holds more than one word's worth of results
    a_grp_bound: assert property (@(posedge clk) disable iff (!rst_n)
        grp_left_reg <= 3'd4)
        else $error("result group overflow");

    // card phases exist only inside a compressed bank
    a_phase_version: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.phase != tabd_pkg::PH_HEADER)
            |-> (state_reg.version == tabd_pkg::VER_COMPRESSED))
        else $error("card phase outside compressed coding");

    // skip count comes from a six-bit length rounded up to words
    a_skip_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.skip <= 5'd16)
        else $error("skip count out of range");

    // while results are pending, a new word is taken only when the group drains in the same cycle
    a_accept_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (din.ready && (grp_left_reg != '0)) |-> (move && (grp_left_reg == 3'd1)))
        else $error("input taken over pending results");

endmodule

/* rtl/tabd_decode.sv */
module tabd_decode (
    input  tabd_pkg::tabd_state_t           state,
    input  logic [tabd_pkg::WORD_W-1:0]     word,
    input  logic                            bank_start,
    input  logic [tabd_pkg::VER_W-1:0]      bank_version,
    input  logic                            extra_header,
    output tabd_pkg::tabd_state_t           state_next,
    output tabd_pkg::tabd_grp_t             grp
);

    tabd_pkg::tabd_state_t                              st;
    logic [tabd_pkg::GRP_N:0][tabd_pkg::WORD_W-1:0]     pc;
    logic [tabd_pkg::GRP_N-1:0]                         found;
    logic [tabd_pkg::CELL_W-1:0]                        id;
    logic [tabd_pkg::ADC_W-1:0]                         a1;
    logic [tabd_pkg::ADC_W-1:0]                         a2;
    logic [6:0]                                         len_adc_rnd;

    // peel the lowest four set pattern bits, one per byte of a data word
    always_comb
    begin
        pc[0] = st.pattern;
        for (int k = 0; k < tabd_pkg::GRP_N; k++)
        begin
            found[k]  = (pc[k] != '0);
            pc[k + 1] = pc[k] & (pc[k] - tabd_pkg::WORD_W'(1));
        end
    end

    assign id          = word[31:16];
    assign a1          = word[15:8];
    assign a2          = word[7:0];
    assign len_adc_rnd = {1'b0, word[12:7]} + 7'd3;

    always_comb
    begin
        st = state;
        if (bank_start)
        begin
            st.version = bank_version;
            st.phase   = tabd_pkg::PH_HEADER;
            st.pattern = '0;
            st.skip    = '0;
            st.drop    = extra_header;
        end

        state_next    = st;
        grp           = '0;
        grp.card_code = '0;

        if (st.drop)
        begin
            state_next.drop = 1'b0;
        end
        else if (st.version < tabd_pkg::VER_COMPRESSED)
        begin
            grp.coding = tabd_pkg::CODING_PAIR;
            if (a1 != '0)
            begin
                grp.cell_id[0] = id;
                grp.adc[0]     = a1;
                grp.cell_id[1] = id + tabd_pkg::CELL_W'(1);
                grp.adc[1]     = a2;
                grp.cnt        = (a2 != '0) ? 3'd2 : 3'd1;
            end
            else
            begin
                grp.cell_id[0] = id + tabd_pkg::CELL_W'(1);
                grp.adc[0]     = a2;
                grp.cnt        = (a2 != '0) ? 3'd1 : 3'd0;
            end
        end
        else if (st.version == tabd_pkg::VER_COMPRESSED)
        begin
            case (st.phase)
                tabd_pkg::PH_HEADER:
                begin
                    state_next.card = word[22:14];
                    state_next.skip = tabd_pkg::SKIP_W'(len_adc_rnd >> 2);
                    if (word[5:0] != '0)
                    begin
                        state_next.phase = tabd_pkg::PH_PATTERN;
                    end
                    else if (len_adc_rnd[6:2] != '0)
                    begin
                        state_next.phase = tabd_pkg::PH_SKIP;
                    end
                    else
                    begin
                        state_next.phase = tabd_pkg::PH_HEADER;
                    end
                end
                tabd_pkg::PH_PATTERN:
                begin
                    state_next.pattern = word;
                    state_next.phase   = tabd_pkg::PH_DATA;
                end
                tabd_pkg::PH_DATA:
                begin
                    grp.coding    = tabd_pkg::CODING_COMPRESSED;
                    grp.card_code = st.card;
                    grp.cnt       = tabd_pkg::GRP_CNT_W'($countones(found));
                    for (int k = 0; k < tabd_pkg::GRP_N; k++)
                    begin
                        grp.channel[k] = tabd_pkg::lsb_index(pc[k]);
                        grp.adc[k]     = word[8*k +: 8];
                    end
                    state_next.pattern = pc[tabd_pkg::GRP_N];
                    if (pc[tabd_pkg::GRP_N] == '0)
                    begin
                        state_next.phase = (st.skip != '0) ? tabd_pkg::PH_SKIP
                                                           : tabd_pkg::PH_HEADER;
                    end
                end
                tabd_pkg::PH_SKIP:
                begin
                    if (st.skip != '0)
                    begin
                        state_next.skip = st.skip - tabd_pkg::SKIP_W'(1);
                    end
                    if (st.skip <= tabd_pkg::SKIP_W'(1))
                    begin
                        state_next.phase = tabd_pkg::PH_HEADER;
                    end
                end
                default:
                begin
                    state_next.phase = tabd_pkg::PH_HEADER;
                end
            endcase
        end
    end

endmodule

/* tb/testbench.sv */
module testbench;

    // Abandon the run after this many cycles without any handshake.
    localparam int STALL_LIMIT  = 2000;
    // Let the group and output registers empty before a write or the end.
    localparam int DRAIN_CYCLES = 8;

    // One result of the block, in port order.
    typedef struct packed {
        logic                        coding;
        logic [tabd_pkg::CELL_W-1:0] cell_id;
        logic [tabd_pkg::CARD_W-1:0] card_code;
        logic [tabd_pkg::CHAN_W-1:0] channel;
        logic [tabd_pkg::ADC_W-1:0]  adc;
        logic                        last;
    } adc_hit_t;

    // One input item. A row with typed set carries its results written out by
    // hand; the decoder below still runs on it to keep its state in step.
    typedef struct {
        logic [tabd_pkg::WORD_W-1:0] word;
        logic                        bank_start;
        logic [tabd_pkg::VER_W-1:0]  bank_version;
        bit                          typed;
        int                          n_typed;
        adc_hit_t                    hit0;
        adc_hit_t                    hit1;
    } stim_row_t;

    localparam adc_hit_t NO_HIT = '0;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    tabd_in_if  din_if ();
    tabd_out_if dout_if ();

    trigger_adc_bank_deframer i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .din     (din_if),
        .dout    (dout_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Decoder copy: bank version, card walk and the register setting.
    logic                        cfg_extra_header;
    tabd_pkg::tabd_phase_t       dec_phase   = tabd_pkg::PH_HEADER;
    logic [tabd_pkg::VER_W-1:0]  dec_version = '0;
    logic                        dec_drop    = 1'b0;
    logic [tabd_pkg::WORD_W-1:0] dec_pattern = '0;
    logic [tabd_pkg::SKIP_W-1:0] dec_skip    = '0;
    logic [tabd_pkg::CARD_W-1:0] dec_card    = '0;

    adc_hit_t  hits_due [$];
    stim_row_t row_in_flight;

    bit src_idle;
    bit sink_idle;
    int stall_left;
    int idle_cycles;
    int fails;
    int words_sent;
    int words_decoded;
    int results_checked;
    int cfg_writes;
    int banks_pair;
    int banks_comp;
    int banks_other;

    // Directed rows: pair coding edges, one full card walk, the zero pattern,
    // the longest skip run cut short by a new bank, and versions above two.
    stim_row_t directed_rows [25] = '{
        // pair coding before any bank start; the low byte is zero
        '{32'h1234_AB00, 1'b0, 8'h00, 1'b1, 1,
          '{tabd_pkg::CODING_PAIR, 16'h1234, 9'h000, 5'd0, 8'hAB, 1'b1}, NO_HIT},
        // all ones: the second cell id wraps to zero
        '{32'hFFFF_FFFF, 1'b1, 8'h01, 1'b1, 2,
          '{tabd_pkg::CODING_PAIR, 16'hFFFF, 9'h000, 5'd0, 8'hFF, 1'b0},
          '{tabd_pkg::CODING_PAIR, 16'h0000, 9'h000, 5'd0, 8'hFF, 1'b1}},
        // both bytes zero; the version field is ignored off a bank start
        '{32'h0000_0000, 1'b0, 8'hFF, 1'b1, 0, NO_HIT, NO_HIT},
        '{32'h0000_0001, 1'b0, 8'h00, 1'b1, 1,
          '{tabd_pkg::CODING_PAIR, 16'h0001, 9'h000, 5'd0, 8'h01, 1'b1}, NO_HIT},
        // compressed: card 0x1FF, three trigger words, ADC length four
        '{32'hFFFF_E243, 1'b1, 8'h02, 1'b1, 0, NO_HIT, NO_HIT},
        '{32'h8000_0001, 1'b0, 8'h5A, 1'b1, 0, NO_HIT, NO_HIT},
        '{32'h0000_7F80, 1'b0, 8'hA5, 1'b1, 2,
          '{tabd_pkg::CODING_COMPRESSED, 16'h0000, 9'h1FF, 5'd0, 8'h80, 1'b0},
          '{tabd_pkg::CODING_COMPRESSED, 16'h0000, 9'h1FF, 5'd31, 8'h7F, 1'b1}},
        '{32'hDEAD_BEEF, 1'b0, 8'h00, 1'b1, 0, NO_HIT, NO_HIT},
        // card 0 with every channel set: eight full data words
        '{32'h0000_0001, 1'b0, 8'h00, 1'b1, 0, NO_HIT, NO_HIT},
        '{32'hFFFF_FFFF, 1'b0, 8'h00, 1'b1, 0, NO_HIT, NO_HIT},
        '{32'h0302_0100, 1'b0, 8'h00, 1'b0, 0, NO_HIT, NO_HIT},
        '{32'hFFFF_FFFF, 1'b0, 8'h00, 1'b0, 0, NO_HIT, NO_HIT},
        '{32'h0000_0000, 1'b0, 8'h00, 1'b0, 0, NO_HIT, NO_HIT},
        '{32'h8040_2010, 1'b0, 8'h00, 1'b0, 0, NO_HIT, NO_HIT},
        '{32'hA5A5_5A5A, 1'b0, 8'h00, 1'b0, 0, NO_HIT, NO_HIT},
        '{32'h7F7F_7F7F, 1'b0, 8'h00, 1'b0, 0, NO_HIT, NO_HIT},
        '{32'h0807_0605, 1'b0, 8'h00, 1'b0, 0, NO_HIT, NO_HIT},
        '{32'h1234_5678, 1'b0, 8'h00, 1'b0, 0, NO_HIT, NO_HIT},
        // zero pattern: one data word is still eaten, with no result
        '{32'h002A_803F, 1'b0, 8'h00, 1'b1, 0, NO_HIT, NO_HIT},
        '{32'h0000_0000, 1'b0, 8'h00, 1'b1, 0, NO_HIT, NO_HIT},
        '{32'hCAFE_F00D, 1'b0, 8'h00, 1'b1, 0, NO_HIT, NO_HIT},
        // no trigger words, ADC length 63: sixteen skips pending
        '{32'h0055_5F80, 1'b0, 8'h00, 1'b1, 0, NO_HIT, NO_HIT},
        // a new bank cuts the skip run short; versions above two stay silent
        '{32'hFFFF_FFFF, 1'b1, 8'h03, 1'b1, 0, NO_HIT, NO_HIT},
        '{32'h0101_0101, 1'b0, 8'h00, 1'b1, 0, NO_HIT, NO_HIT},
        '{32'h5555_AAAA, 1'b1, 8'hFF, 1'b1, 0, NO_HIT, NO_HIT}
    };

    // Decode one accepted word and return the results it causes, in order.
    function automatic void decode_word(input logic [tabd_pkg::WORD_W-1:0] w,
                                        input logic bank_start,
                                        input logic [tabd_pkg::VER_W-1:0] bank_version,
                                        output adc_hit_t hits [tabd_pkg::GRP_N],
                                        output int n);
        logic [5:0] len_trig;
        logic [5:0] len_adc;
        int         sh;
        n = 0;
        sh = 0;
        for (int k = 0; k < tabd_pkg::GRP_N; k++)
        begin
            hits[k] = NO_HIT;
        end
        if (bank_start)
        begin
            dec_version = bank_version;
            dec_phase   = tabd_pkg::PH_HEADER;
            dec_pattern = '0;
            dec_skip    = '0;
            dec_drop    = cfg_extra_header;
        end
        if (dec_drop)
        begin
            dec_drop = 1'b0;
            return;
        end
        if (dec_version < tabd_pkg::VER_COMPRESSED)
        begin
            if (w[15:8] != '0)
            begin
                hits[n] = '{tabd_pkg::CODING_PAIR, w[31:16], 9'h000, 5'd0,
                            w[15:8], 1'b0};
                n++;
            end
            if (w[7:0] != '0)
            begin
                hits[n] = '{tabd_pkg::CODING_PAIR, w[31:16] + 16'd1, 9'h000, 5'd0,
                            w[7:0], 1'b0};
                n++;
            end
        end
        else if (dec_version == tabd_pkg::VER_COMPRESSED)
        begin
            case (dec_phase)
                tabd_pkg::PH_HEADER:
                begin
                    len_trig = w[5:0];
                    len_adc  = w[12:7];
                    dec_card = w[22:14];
                    dec_skip = tabd_pkg::SKIP_W'((int'(len_adc) + 3) / 4);
                    if (len_trig != '0)
                        dec_phase = tabd_pkg::PH_PATTERN;
                    else
                        dec_phase = (dec_skip != '0) ? tabd_pkg::PH_SKIP
                                                     : tabd_pkg::PH_HEADER;
                end
                tabd_pkg::PH_PATTERN:
                begin
                    dec_pattern = w;
                    dec_phase   = tabd_pkg::PH_DATA;
                end
                tabd_pkg::PH_DATA:
                begin
                    // hand bytes, low first, to the lowest channels still open
                    for (int b = 0; b < tabd_pkg::WORD_W && sh < tabd_pkg::WORD_W; b++)
                    begin
                        if (dec_pattern[b])
                        begin
                            hits[n] = '{tabd_pkg::CODING_COMPRESSED, 16'h0000, dec_card,
                                        tabd_pkg::CHAN_W'(b), w[sh +: 8], 1'b0};
                            dec_pattern[b] = 1'b0;
                            sh += 8;
                            n++;
                        end
                    end
                    if (dec_pattern == '0)
                        dec_phase = (dec_skip != '0) ? tabd_pkg::PH_SKIP
                                                     : tabd_pkg::PH_HEADER;
                end
                tabd_pkg::PH_SKIP:
                begin
                    if (dec_skip != '0)
                        dec_skip--;
                    if (dec_skip == '0)
                        dec_phase = tabd_pkg::PH_HEADER;
                end
                default:
                    dec_phase = tabd_pkg::PH_HEADER;
            endcase
        end
        if (n > 0)
            hits[n-1].last = 1'b1;
    endfunction

    // Check every result against the oldest pending one, then queue the
    // results of any word accepted at this edge. The check runs first, so a
    // result cannot be matched against a word taken in the same cycle.
    always @(posedge clk)
    begin : monitor
        adc_hit_t hits [tabd_pkg::GRP_N];
        adc_hit_t want;
        int       n;
        bit       moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (dout_if.valid === 1'b1 && dout_if.ready === 1'b1)
            begin
                moved = 1'b1;
                results_checked++;
                if (hits_due.size() == 0)
                begin
                    $error("result with nothing pending: adc %0h channel %0d",
                           dout_if.adc, dout_if.channel);
                    fails++;
                end
                else
                begin
                    want = hits_due.pop_front();
                    if (dout_if.coding !== want.coding)
                    begin
                        $error("coding: expected %0d, got %0d", want.coding, dout_if.coding);
                        fails++;
                    end
                    if (dout_if.cell_id !== want.cell_id)
                    begin
                        $error("cell_id: expected %0h, got %0h", want.cell_id, dout_if.cell_id);
                        fails++;
                    end
                    if (dout_if.card_code !== want.card_code)
                    begin
                        $error("card_code: expected %0h, got %0h", want.card_code,
                               dout_if.card_code);
                        fails++;
                    end
                    if (dout_if.channel !== want.channel)
                    begin
                        $error("channel: expected %0d, got %0d", want.channel, dout_if.channel);
                        fails++;
                    end
                    if (dout_if.adc !== want.adc)
                    begin
                        $error("adc: expected %0h, got %0h", want.adc, dout_if.adc);
                        fails++;
                    end
                    if (dout_if.last !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, dout_if.last);
                        fails++;
                    end
                end
            end
            if (din_if.valid === 1'b1 && din_if.ready === 1'b1)
            begin
                moved = 1'b1;
                decode_word(din_if.word, din_if.bank_start, din_if.bank_version, hits, n);
                if (row_in_flight.typed)
                begin
                    // take the hand-written results for this row
                    if (row_in_flight.n_typed > 0)
                        hits_due.push_back(row_in_flight.hit0);
                    if (row_in_flight.n_typed > 1)
                        hits_due.push_back(row_in_flight.hit1);
                end
                else
                begin
                    for (int k = 0; k < n; k++)
                    begin
                        hits_due.push_back(hits[k]);
                    end
                end
            end
            if (psel && penable && pwrite && pready)
                moved = 1'b1;
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("no handshake for %0d cycles, %0d results still pending",
                         STALL_LIMIT, hits_due.size());
                $display("trigger_adc_bank_deframer regression: fail");
                $finish;
            end
        end
    end

    // Output side: while enabled, now and then hold ready low for a random burst.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left--;
            dout_if.ready <= 1'b0;
        end
        else if (sink_idle && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 9);
            dout_if.ready <= 1'b0;
        end
        else
        begin
            dout_if.ready <= 1'b1;
        end
    end

    // Present one item, possibly after a gap, and hold it until it is taken.
    task automatic send_word(input stim_row_t row);
        @(negedge clk);
        if (src_idle && $urandom_range(0, 3) == 0)
        begin
            din_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        row_in_flight = row;
        din_if.valid        <= 1'b1;
        din_if.word         <= row.word;
        din_if.bank_start   <= row.bank_start;
        din_if.bank_version <= row.bank_version;
        do
            @(posedge clk);
        while (!(din_if.valid === 1'b1 && din_if.ready === 1'b1));
        words_sent++;
    endtask

    // Drop valid, wait for every pending result, then let the pipe empty.
    task automatic settle();
        @(negedge clk);
        din_if.valid <= 1'b0;
        while (hits_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Write the header-drop register through a setup and an access cycle.
    task automatic set_extra_header(input logic v);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {tabd_pkg::REG_EXTRA_HEADER, 2'b00};
        pwdata  <= {31'd0, v};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        cfg_extra_header = v;
        cfg_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Build and send one bank. Most compressed banks are well-formed card
    // sequences with random content, the rest garbage words; some banks of
    // every version, silent ones too, are cut short by the next bank start.
    task automatic play_bank();
        logic [tabd_pkg::VER_W-1:0]  ver;
        logic [tabd_pkg::WORD_W-1:0] words [$];
        logic [tabd_pkg::WORD_W-1:0] w;
        logic [5:0]                  trig;
        logic [5:0]                  adcl;
        logic [tabd_pkg::WORD_W-1:0] pat;
        stim_row_t                   r;
        int                          pick;
        int                          nd;
        int                          cut;
        pick = $urandom_range(0, 19);
        if (pick < 5)
            ver = tabd_pkg::VER_W'($urandom_range(0, 1));
        else if (pick < 17)
            ver = tabd_pkg::VER_COMPRESSED;
        else
            ver = tabd_pkg::VER_W'($urandom_range(3, 255));
        // this word is the detector header when the drop is on
        if (cfg_extra_header)
            words.push_back($urandom);
        if (ver < tabd_pkg::VER_COMPRESSED)
        begin
            repeat ($urandom_range(1, 8))
            begin
                w = $urandom;
                case ($urandom_range(0, 3))
                    0: w[15:8] = '0;
                    1: w[7:0]  = '0;
                    2: w[15:0] = '0;
                    default: ;
                endcase
                words.push_back(w);
            end
            banks_pair++;
        end
        else if (ver == tabd_pkg::VER_COMPRESSED)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                repeat ($urandom_range(1, 12)) words.push_back($urandom);
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                begin
                    trig = ($urandom_range(0, 9) == 0) ? 6'd0 : 6'($urandom_range(1, 63));
                    case ($urandom_range(0, 4))
                        0: adcl = 6'd63;
                        1: adcl = 6'($urandom_range(0, 63));
                        default: adcl = 6'($urandom_range(0, 8));
                    endcase
                    // control, card code and the spare bits stay random
                    w = $urandom;
                    w[5:0]  = trig;
                    w[12:7] = adcl;
                    words.push_back(w);
                    if (trig != '0)
                    begin
                        case ($urandom_range(0, 9))
                            0: pat = '1;
                            1: pat = '0;
                            2, 3, 4: pat = $urandom & $urandom & $urandom;
                            default: pat = $urandom;
                        endcase
                        words.push_back(pat);
                        nd = ($countones(pat) + 3) / 4;
                        if (nd == 0)
                            nd = 1;
                        repeat (nd) words.push_back($urandom);
                    end
                    repeat ((int'(adcl) + 3) / 4) words.push_back($urandom);
                end
            end
            banks_comp++;
        end
        else
        begin
            repeat ($urandom_range(1, 4)) words.push_back($urandom);
            banks_other++;
        end
        // cut some banks short so the next bank start lands mid-card
        if ($urandom_range(0, 7) == 0)
        begin
            cut = $urandom_range(1, words.size());
            while (words.size() > cut)
                void'(words.pop_back());
        end
        foreach (words[i])
        begin
            r.word         = words[i];
            r.bank_start   = (i == 0);
            r.bank_version = (i == 0) ? ver : tabd_pkg::VER_W'($urandom);
            r.typed        = 1'b0;
            r.n_typed      = 0;
            r.hit0         = NO_HIT;
            r.hit1         = NO_HIT;
            send_word(r);
            if (ver <= tabd_pkg::VER_COMPRESSED && !(i == 0 && cfg_extra_header))
                words_decoded++;
        end
    endtask

    // Settle, set the header drop, pick the idling mix, then play banks.
    task automatic run_phase(input logic extra, input bit src_on, input bit sink_on,
                             input int quota);
        int start;
        settle();
        set_extra_header(extra);
        src_idle  = src_on;
        sink_idle = sink_on;
        start = words_sent;
        while (words_sent - start < quota)
            play_bank();
    endtask

    initial
    begin
        din_if.valid        = 1'b0;
        din_if.word         = '0;
        din_if.bank_start   = 1'b0;
        din_if.bank_version = '0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        row_in_flight       = '{'0, 1'b0, '0, 1'b0, 0, NO_HIT, NO_HIT};
        cfg_extra_header    = 1'b0;
        src_idle            = 1'b0;
        sink_idle           = 1'b0;
        words_sent          = 0;
        words_decoded       = 0;
        cfg_writes          = 0;
        banks_pair          = 0;
        banks_comp          = 0;
        banks_other         = 0;

        // hold reset low, then release it away from the rising edge
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        set_extra_header(1'b0);
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        foreach (directed_rows[i])
            send_word(directed_rows[i]);

        // drop on with idling both sides, drop off with output stalls only,
        // then drop on again at full rate to finish
        run_phase(1'b1, 1'b1, 1'b1, 150);
        run_phase(1'b0, 1'b0, 1'b1, 150);
        run_phase(1'b1, 1'b0, 1'b0, 135);
        settle();

        $display("covered %0d items (%0d directed, %0d decoded) over %0d pair,",
                 words_sent, $size(directed_rows), words_decoded, banks_pair);
        $display("%0d compressed, %0d silent banks; checked %0d results, %0d drop writes",
                 banks_comp, banks_other, results_checked, cfg_writes);
        if (fails == 0)
            $display("trigger_adc_bank_deframer regression: pass");
        else
            $display("trigger_adc_bank_deframer regression: fail");
        $finish;
    end

endmodule

/* files.f */
rtl/tabd_pkg.sv
rtl/tabd_if.sv
rtl/tabd_decode.sv
rtl/trigger_adc_bank_deframer.sv
tb/testbench.sv
